[rtl/core/mfa_pkg.sv]
// Shared types and codes for the multi-format signed ALU.
`default_nettype none

package mfa_pkg;

    localparam int WORD_W    = 16;
    localparam int DIV_STEPS = WORD_W;
    localparam int PROD_W    = 2 * WORD_W;

    localparam logic [1:0] FMT_SM = 2'd0;
    localparam logic [1:0] FMT_OC = 2'd1;
    localparam logic [1:0] FMT_TC = 2'd2;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [PROD_W-1:0] RESULT_MAX = PROD_W'(32767);

    typedef struct packed {
        logic [1:0]        number_format;
        logic [1:0]        command;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_bits;
        logic              overflow;
        logic              divide_by_zero;
    } out_t;

    typedef struct packed {
        logic [1:0]          fmt;
        logic [1:0]          cmd;
        logic                neg_a;
        logic                neg_b;
        logic [WORD_W-1:0]   mag_a;
        logic [WORD_W-1:0]   mag_b;
        logic signed [WORD_W:0] val_a;
        logic signed [WORD_W:0] val_b;
    } dec_t;

    typedef struct packed {
        logic [1:0]        fmt;
        logic [1:0]        cmd;
        logic              dbz;
        logic              r_neg;
        logic [PROD_W-1:0] r_mag;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
    } pipe_t;

endpackage

`default_nettype wire

[rtl/core/multi_format_signed_alu16.sv]
// Top level of the multi-format signed 16-bit ALU.
//
// Usage:
//   req carries one item: number format, command and two 16-bit operand
//   patterns; it is taken when req_valid and req_ready are high together.
//   rsp carries the encoded result with its overflow and divide-by-zero
//   flags; it is taken when rsp_valid and rsp_ready are high together.
//   Every item gives exactly one result, in order.
// Pipeline: every command passes through 19 register stages (decode,
//   arithmetic, sixteen division cells, one output register).
// Throughput: one item per cycle unless rsp stalls; each division cell
//   resolves one quotient bit, so the cell chain sets the latency, not
//   the rate.
// Stall: each stage holds its item while the next one is full and stalled;
//   empty stages keep filling, so req_ready falls only once the whole chain
//   is full behind a stalled rsp.
// Reset: rst_n empties every stage; no state survives between items.
`default_nettype none

module multi_format_signed_alu16 (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mfa_pkg::in_t  req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mfa_pkg::out_t      rsp
);
    import mfa_pkg::*;

    dec_t  dec;
    logic  dec_valid;
    logic  dec_ready;
    pipe_t chain [0:DIV_STEPS];
    logic  chain_valid [0:DIV_STEPS];
    logic  chain_ready [0:DIV_STEPS];

    mfa_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up       (req),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dn       (dec)
    );

    mfa_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .up       (dec),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn       (chain[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        mfa_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up       (chain[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn       (chain[i+1])
        );
    end

    mfa_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[DIV_STEPS]),
        .up_ready (chain_ready[DIV_STEPS]),
        .up       (chain[DIV_STEPS]),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn       (rsp)
    );

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.overflow && rsp.divide_by_zero))
        else $error("overflow and divide-by-zero raised together");

    a_flag_zero_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.overflow || rsp.divide_by_zero)) |-> (rsp.result_bits == '0))
        else $error("flagged item carries nonzero result bits");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("input blocked without a stalled output");

endmodule

`default_nettype wire

[rtl/core/mfa_decode.sv]
// Operand decode stage: sign, magnitude and signed value of both operands.
`default_nettype none

module mfa_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire mfa_pkg::in_t  up,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output mfa_pkg::dec_t      dn
);
    import mfa_pkg::*;

    typedef struct packed {
        logic                   neg;
        logic [WORD_W-1:0]      mag;
        logic signed [WORD_W:0] val;
    } opnd_t;

    function automatic opnd_t decode_op(input logic [1:0] fmt, input logic [WORD_W-1:0] bits);
        opnd_t             o;
        logic              s;
        logic [WORD_W-2:0] low;
        s   = bits[WORD_W-1];
        low = bits[WORD_W-2:0];
        unique case (fmt)
            FMT_SM:  o.mag = {1'b0, low};
            FMT_OC:  o.mag = s ? {1'b0, ~low} : {1'b0, low};
            default: o.mag = s ? (WORD_W'(0) - bits) : {1'b0, low};
        endcase
        o.neg = s && (o.mag != '0);
        if (fmt == FMT_SM || fmt == FMT_OC)
        begin
            o.val = o.neg ? -$signed({1'b0, o.mag}) : $signed({1'b0, o.mag});
        end
        else
        begin
            o.val = $signed({s, bits});
        end
        return o;
    endfunction

    logic  valid_reg;
    dec_t  data_reg;
    dec_t  data_next;
    opnd_t opa;
    opnd_t opb;

    always_comb
    begin
        opa = decode_op(up.number_format, up.operand_a);
        opb = decode_op(up.number_format, up.operand_b);
        data_next.fmt   = up.number_format;
        data_next.cmd   = up.command;
        data_next.neg_a = opa.neg;
        data_next.neg_b = opb.neg;
        data_next.mag_a = opa.mag;
        data_next.mag_b = opb.mag;
        data_next.val_a = opa.val;
        data_next.val_b = opb.val;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mfa_arith.sv]
// Arithmetic stage: add, subtract, multiply, and set-up of the divider chain.
`default_nettype none

module mfa_arith (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire mfa_pkg::dec_t up,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output mfa_pkg::pipe_t     dn
);
    import mfa_pkg::*;

    logic                     valid_reg;
    pipe_t                    data_reg;
    pipe_t                    data_next;
    logic signed [WORD_W+1:0] sum;
    logic [WORD_W+1:0]        sum_mag;
    logic [PROD_W-1:0]        prod;

    always_comb
    begin
        if (up.cmd == CMD_SUB)
        begin
            sum = (WORD_W+2)'(up.val_a) - (WORD_W+2)'(up.val_b);
        end
        else
        begin
            sum = (WORD_W+2)'(up.val_a) + (WORD_W+2)'(up.val_b);
        end
        sum_mag = sum[WORD_W+1] ? (WORD_W+2)'(-sum) : sum;
        prod    = up.mag_a * up.mag_b;

        data_next.fmt = up.fmt;
        data_next.cmd = up.cmd;
        data_next.dbz = (up.cmd == CMD_DIV) && (up.mag_b == '0);
        data_next.rem = '0;
        data_next.quo = up.mag_a;
        data_next.dvs = up.mag_b;
        unique case (up.cmd)
            CMD_ADD, CMD_SUB:
            begin
                data_next.r_neg = sum[WORD_W+1];
                data_next.r_mag = PROD_W'(sum_mag);
            end
            CMD_MUL:
            begin
                data_next.r_neg = up.neg_a ^ up.neg_b;
                data_next.r_mag = prod;
            end
            default:
            begin
                data_next.r_neg = up.neg_a ^ up.neg_b;
                data_next.r_mag = '0;
            end
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mfa_div_cell.sv]
// One restoring-division cell: produces one quotient bit and passes the item on.
`default_nettype none

module mfa_div_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire mfa_pkg::pipe_t up,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output mfa_pkg::pipe_t      dn
);
    import mfa_pkg::*;

    logic              valid_reg;
    pipe_t             data_reg;
    pipe_t             data_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic              ge;

    always_comb
    begin
        shifted   = {up.rem, up.quo[WORD_W-1]};
        ge        = shifted >= {1'b0, up.dvs};
        trial     = shifted - {1'b0, up.dvs};
        data_next = up;
        data_next.rem = ge ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
        data_next.quo = {up.quo[WORD_W-2:0], ge};
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.dvs != '0) |-> (data_reg.rem < data_reg.dvs))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

[rtl/core/mfa_encode.sv]
// Output stage: range check, flag handling and re-encoding into the item's format.
`default_nettype none

module mfa_encode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire mfa_pkg::pipe_t up,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output mfa_pkg::out_t       dn
);
    import mfa_pkg::*;

    logic              valid_reg;
    out_t              data_reg;
    out_t              data_next;
    logic [PROD_W-1:0] mag;
    logic              ovf;

    always_comb
    begin
        mag = (up.cmd == CMD_DIV) ? PROD_W'(up.quo) : up.r_mag;
        ovf = !up.dbz && (mag > RESULT_MAX);
        data_next.divide_by_zero = up.dbz;
        data_next.overflow       = ovf;
        if (up.dbz || ovf)
        begin
            data_next.result_bits = '0;
        end
        else if (!up.r_neg || mag == '0)
        begin
            data_next.result_bits = mag[WORD_W-1:0];
        end
        else
        begin
            unique case (up.fmt)
                FMT_SM:  data_next.result_bits = {1'b1, mag[WORD_W-2:0]};
                FMT_OC:  data_next.result_bits = ~mag[WORD_W-1:0];
                default: data_next.result_bits = WORD_W'(0) - mag[WORD_W-1:0];
            endcase
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
